// ===== sv/lrp_pkg.sv =====
package lrp_pkg;

	localparam int SAMPLE_W   = 20;
	localparam int RATE_W     = 18;
	localparam int PCM_W      = 16;
	localparam int IDX_W      = 8;
	localparam int MAX_RATIO  = 16;
	localparam int FRAC_W     = 16;
	localparam int FULL_SCALE = 65536;
	localparam int PCM_SCALE  = 32767;

	localparam int CNT_W     = $clog2(MAX_RATIO + 1);
	localparam int LIM_W     = RATE_W + CNT_W;
	localparam int ACC_W     = RATE_W + CNT_W + 1;
	localparam int SUM_W     = ACC_W + 1;
	localparam int DIV_CNT_W = $clog2(FRAC_W);
	localparam int DIFF_W    = SAMPLE_W + 1;
	localparam int PROD_W    = DIFF_W + FRAC_W + 1;
	localparam int V_W       = PROD_W - FRAC_W;
	localparam int CLAMP_W   = $clog2(FULL_SCALE) + 2;
	localparam int SC_W      = CLAMP_W + PCM_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [PCM_W-1:0]    pcm_t;
	typedef logic [RATE_W-1:0]          rate_t;
	typedef logic [IDX_W-1:0]           reg_idx_t;

	localparam reg_idx_t REG_IN_RATE  = reg_idx_t'(0);
	localparam reg_idx_t REG_OUT_RATE = reg_idx_t'(1);

	localparam rate_t IN_RATE_RST  = rate_t'(48000);
	localparam rate_t OUT_RATE_RST = rate_t'(16000);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_MUL,
		ST_SCALE,
		ST_LOAD,
		ST_EMIT,
		ST_TAIL
	} state_t;

	typedef struct packed {
		logic load_item;
		logic div_start;
		logic div_step;
		logic mul;
		logic scale;
		logic load_out;
		logic advance;
		logic wrap;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_go;
		logic tail_go;
		logic div_done;
		logic tail_mode;
	} sts_t;

endpackage

// ===== sv/lrp_in_if.sv =====
interface lrp_in_if;
	logic             valid;
	logic             ready;
	lrp_pkg::sample_t sample;
	logic             last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

// ===== sv/lrp_out_if.sv =====
interface lrp_out_if;
	logic          valid;
	logic          ready;
	lrp_pkg::pcm_t pcm;
	logic          run_end;

	modport source (output valid, output pcm, output run_end, input ready);
	modport sink (input valid, input pcm, input run_end, output ready);
endinterface

// ===== sv/lrp_cfg_if.sv =====
interface lrp_cfg_if;
	logic              valid;
	logic              ready;
	lrp_pkg::reg_idx_t index;
	lrp_pkg::rate_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/linear_resampler_to_pcm16.sv =====
// Linear interpolation sample rate converter with 16-bit PCM output. One input beat
// is taken at a time; it produces n interval results and, on a last beat, m tail
// results (each at most 16). Every interval result runs the bit-serial fraction
// divider, then multiply, scale, load and output, and a tail result skips the
// divider and multiply. Rate registers take effect from the next input beat.
module linear_resampler_to_pcm16 (
	input logic       clk,
	input logic       arst_n,
	lrp_in_if.sink    samples,
	lrp_out_if.source results,
	lrp_cfg_if.sink   cfg
);

	lrp_pkg::cmd_t cmd;
	lrp_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	lrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lrp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.sample    (samples.sample),
		.last      (samples.last),
		.cmd       (cmd),
		.sts       (sts),
		.pcm       (results.pcm),
		.run_end   (results.run_end)
	);

endmodule

// ===== sv/lrp_datapath.sv =====
module lrp_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  lrp_pkg::reg_idx_t cfg_index,
	input  lrp_pkg::rate_t    cfg_data,
	input  lrp_pkg::sample_t  sample,
	input  logic              last,
	input  lrp_pkg::cmd_t     cmd,
	output lrp_pkg::sts_t     sts,
	output lrp_pkg::pcm_t     pcm,
	output logic              run_end
);

	lrp_pkg::rate_t   in_rate_q, out_rate_q;
	lrp_pkg::rate_t   ir_q, orr_q, phase_q;
	lrp_pkg::sample_t cur_q, prev_q;
	logic             last_q, have_prev_q, tail_q;
	logic [lrp_pkg::ACC_W-1:0]     acc_q;
	logic [lrp_pkg::CNT_W-1:0]     cnt_q;
	lrp_pkg::rate_t                rem_q;
	logic [lrp_pkg::FRAC_W-1:0]    quo_q;
	logic [lrp_pkg::DIV_CNT_W-1:0] dcnt_q;
	logic signed [lrp_pkg::PROD_W-1:0] prod_s1;
	logic signed [lrp_pkg::SC_W-1:0]   sc_s2;
	lrp_pkg::pcm_t    pcm_q;
	logic             run_end_q;

	// effective rates
	lrp_pkg::rate_t             ir_eff, or_raw, orr_eff;
	logic [lrp_pkg::LIM_W-1:0]  lim;

	always_comb begin
		ir_eff = (in_rate_q == '0) ? lrp_pkg::rate_t'(1) : in_rate_q;
		or_raw = (out_rate_q == '0) ? lrp_pkg::rate_t'(1) : out_rate_q;
		lim = lrp_pkg::LIM_W'(ir_eff) * lrp_pkg::LIM_W'(lrp_pkg::MAX_RATIO);
		orr_eff = (lrp_pkg::LIM_W'(or_raw) > lim) ? lrp_pkg::RATE_W'(lim) : or_raw;
	end

	// phase arithmetic and lookahead
	logic [lrp_pkg::SUM_W-1:0] acc_x, orr_x, ir_x, acc_nx, acc_nx2, wrap_nx;
	logic [lrp_pkg::ACC_W-1:0] acc_wrap;
	logic more_cnt, more_a, more_t, more_tail, run_end_nx;

	always_comb begin
		acc_x   = lrp_pkg::SUM_W'(acc_q);
		orr_x   = lrp_pkg::SUM_W'(orr_q);
		ir_x    = lrp_pkg::SUM_W'(ir_q);
		acc_nx  = acc_x + ir_x;
		acc_nx2 = acc_nx + ir_x;
		wrap_nx = (acc_nx >= orr_x) ? acc_nx - orr_x : '0;
		acc_wrap = (acc_x >= orr_x) ? lrp_pkg::ACC_W'(acc_x - orr_x) : '0;
		more_cnt  = cnt_q < lrp_pkg::CNT_W'(lrp_pkg::MAX_RATIO - 1);
		more_a    = (acc_nx < orr_x) && more_cnt;
		more_t    = last_q && ((wrap_nx + ir_x) <= orr_x);
		more_tail = (acc_nx2 <= orr_x) && more_cnt;
		run_end_nx = tail_q ? !more_tail : !(more_a || more_t);
	end

	assign sts.scan_go = have_prev_q && !tail_q && (acc_x < orr_x)
		&& (cnt_q < lrp_pkg::CNT_W'(lrp_pkg::MAX_RATIO));
	assign sts.tail_go = last_q && (acc_nx <= orr_x)
		&& (cnt_q < lrp_pkg::CNT_W'(lrp_pkg::MAX_RATIO));
	assign sts.div_done  = dcnt_q == lrp_pkg::DIV_CNT_W'(lrp_pkg::FRAC_W - 1);
	assign sts.tail_mode = tail_q;

	// restoring divider step
	logic [lrp_pkg::RATE_W:0] rem_sh;
	logic                     rem_ge;

	always_comb begin
		rem_sh = {rem_q, 1'b0};
		rem_ge = rem_sh >= {1'b0, orr_q};
	end

	// interpolation and scaling
	logic signed [lrp_pkg::DIFF_W-1:0]  diff;
	logic signed [lrp_pkg::V_W-1:0]     v;
	logic signed [lrp_pkg::CLAMP_W-1:0] vc;
	logic signed [lrp_pkg::SC_W-1:0]    sc_adj;
	logic signed [lrp_pkg::PCM_W-1:0]   k_scale;

	always_comb begin
		k_scale = lrp_pkg::PCM_W'(lrp_pkg::PCM_SCALE);
		diff = lrp_pkg::DIFF_W'(cur_q) - lrp_pkg::DIFF_W'(prev_q);
		if (tail_q) begin
			v = lrp_pkg::V_W'(cur_q);
		end else begin
			v = lrp_pkg::V_W'(prev_q) + lrp_pkg::V_W'(prod_s1 >>> lrp_pkg::FRAC_W);
		end
		if (v > lrp_pkg::V_W'(lrp_pkg::FULL_SCALE)) begin
			vc = lrp_pkg::CLAMP_W'(lrp_pkg::FULL_SCALE);
		end else if (v < lrp_pkg::V_W'(-lrp_pkg::FULL_SCALE)) begin
			vc = lrp_pkg::CLAMP_W'(-lrp_pkg::FULL_SCALE);
		end else begin
			vc = lrp_pkg::CLAMP_W'(v);
		end
		sc_adj = sc_s2[lrp_pkg::SC_W-1]
			? sc_s2 + lrp_pkg::SC_W'(lrp_pkg::FULL_SCALE - 1) : sc_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rate_q   <= lrp_pkg::IN_RATE_RST;
			out_rate_q  <= lrp_pkg::OUT_RATE_RST;
			have_prev_q <= 1'b0;
			phase_q     <= '0;
			prev_q      <= '0;
			last_q      <= 1'b0;
			tail_q      <= 1'b0;
			cnt_q       <= '0;
			dcnt_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					lrp_pkg::REG_IN_RATE:  in_rate_q  <= cfg_data;
					lrp_pkg::REG_OUT_RATE: out_rate_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load_item) begin
				last_q <= last;
				tail_q <= 1'b0;
				cnt_q  <= '0;
			end
			if (cmd.div_start) begin
				dcnt_q <= '0;
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.advance) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.wrap) begin
				cnt_q  <= '0;
				tail_q <= 1'b1;
			end
			if (cmd.commit) begin
				if (last_q) begin
					have_prev_q <= 1'b0;
					phase_q     <= '0;
					prev_q      <= '0;
				end else begin
					have_prev_q <= 1'b1;
					phase_q     <= acc_q[lrp_pkg::RATE_W-1:0];
					prev_q      <= cur_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cur_q <= sample;
			acc_q <= lrp_pkg::ACC_W'(phase_q);
			ir_q  <= ir_eff;
			orr_q <= orr_eff;
		end
		if (cmd.advance) begin
			acc_q <= lrp_pkg::ACC_W'(acc_nx);
		end
		if (cmd.wrap && have_prev_q) begin
			acc_q <= acc_wrap;
		end
		if (cmd.div_start) begin
			rem_q <= acc_q[lrp_pkg::RATE_W-1:0];
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? lrp_pkg::RATE_W'(rem_sh - {1'b0, orr_q})
				: lrp_pkg::RATE_W'(rem_sh);
			quo_q <= {quo_q[lrp_pkg::FRAC_W-2:0], rem_ge};
		end
		if (cmd.mul) begin
			prod_s1 <= diff * $signed({1'b0, quo_q});
		end
		if (cmd.scale) begin
			sc_s2 <= vc * k_scale;
		end
		if (cmd.load_out) begin
			pcm_q     <= lrp_pkg::PCM_W'(sc_adj >>> lrp_pkg::FRAC_W);
			run_end_q <= run_end_nx;
		end
	end

	assign pcm     = pcm_q;
	assign run_end = run_end_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lrp_pkg::CNT_W'(lrp_pkg::MAX_RATIO))
		else $error("result count past ratio limit");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && last_q) |=> (!have_prev_q && phase_q == '0))
		else $error("stream state not cleared after last beat");

endmodule

// ===== sv/lrp_ctrl.sv =====
module lrp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  lrp_pkg::sts_t sts,
	output lrp_pkg::cmd_t cmd
);

	lrp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrp_pkg::ST_IDLE:  if (in_valid) state_d = lrp_pkg::ST_SCAN;
			lrp_pkg::ST_SCAN:  state_d = sts.scan_go ? lrp_pkg::ST_DIV : lrp_pkg::ST_TAIL;
			lrp_pkg::ST_DIV:   if (sts.div_done) state_d = lrp_pkg::ST_MUL;
			lrp_pkg::ST_MUL:   state_d = lrp_pkg::ST_SCALE;
			lrp_pkg::ST_SCALE: state_d = lrp_pkg::ST_LOAD;
			lrp_pkg::ST_LOAD:  state_d = lrp_pkg::ST_EMIT;
			lrp_pkg::ST_EMIT: begin
				if (out_ready) begin
					state_d = sts.tail_mode ? lrp_pkg::ST_TAIL : lrp_pkg::ST_SCAN;
				end
			end
			lrp_pkg::ST_TAIL:  state_d = sts.tail_go ? lrp_pkg::ST_SCALE : lrp_pkg::ST_IDLE;
			default:           state_d = lrp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			lrp_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			lrp_pkg::ST_SCAN: begin
				cmd.div_start = sts.scan_go;
				cmd.wrap      = !sts.scan_go;
			end
			lrp_pkg::ST_DIV:   cmd.div_step = 1'b1;
			lrp_pkg::ST_MUL:   cmd.mul      = 1'b1;
			lrp_pkg::ST_SCALE: cmd.scale    = 1'b1;
			lrp_pkg::ST_LOAD:  cmd.load_out = 1'b1;
			lrp_pkg::ST_EMIT: begin
				out_valid   = 1'b1;
				cmd.advance = out_ready;
			end
			lrp_pkg::ST_TAIL:  cmd.commit = !sts.tail_go;
			default: ;
		endcase
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_div_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && sts.div_done) |=> (state_q == lrp_pkg::ST_MUL))
		else $error("divider finish not followed by multiply");

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		lrp_pkg::pcm_t pcm;
		logic          run_end;
	} pcm_beat_t;

	class pcm_scoreboard;
		lrp_pkg::rate_t   in_rate;
		lrp_pkg::rate_t   out_rate;
		lrp_pkg::sample_t held;
		bit               have_held;
		lrp_pkg::rate_t   phase;
		pcm_beat_t        pcm_q[$];
		int unsigned      errors;

		function new();
			in_rate   = lrp_pkg::IN_RATE_RST;
			out_rate  = lrp_pkg::OUT_RATE_RST;
			held      = '0;
			have_held = 1'b0;
			phase     = '0;
			errors    = 0;
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function int pending();
			return pcm_q.size();
		endfunction

		function void set_rate(lrp_pkg::reg_idx_t idx, lrp_pkg::rate_t val);
			if (idx == lrp_pkg::REG_IN_RATE)
				in_rate = val;
			else if (idx == lrp_pkg::REG_OUT_RATE)
				out_rate = val;
		endfunction

		// blend two samples at pos/span, clamp to full scale, scale to pcm
		function lrp_pkg::pcm_t blend_pcm(longint a, longint b, longint pos, longint span);
			longint frac;
			longint mix;
			longint v;
			frac = (pos <<< lrp_pkg::FRAC_W) / span;
			mix  = a * (lrp_pkg::FULL_SCALE - frac) + b * frac;
			v    = mix >>> lrp_pkg::FRAC_W;
			if (v > lrp_pkg::FULL_SCALE)
				v = lrp_pkg::FULL_SCALE;
			if (v < -lrp_pkg::FULL_SCALE)
				v = -lrp_pkg::FULL_SCALE;
			return lrp_pkg::pcm_t'((v * lrp_pkg::PCM_SCALE) / lrp_pkg::FULL_SCALE);
		endfunction

		function void push_pcm(lrp_pkg::pcm_t p);
			pcm_beat_t b;
			b.pcm     = p;
			b.run_end = 1'b0;
			pcm_q.push_back(b);
		endfunction

		function void note_sample(lrp_pkg::sample_t s, logic last);
			longint ir;
			longint orr;
			longint acc;
			longint cur;
			int     cnt;
			int     first_new;
			ir  = (in_rate == 0) ? 1 : in_rate;
			orr = (out_rate == 0) ? 1 : out_rate;
			if (orr > ir * lrp_pkg::MAX_RATIO)
				orr = ir * lrp_pkg::MAX_RATIO;
			acc       = phase;
			cur       = s;
			first_new = pcm_q.size();
			if (have_held) begin
				cnt = 0;
				while (acc < orr && cnt < lrp_pkg::MAX_RATIO) begin
					push_pcm(blend_pcm(held, cur, acc, orr));
					cnt++;
					acc += ir;
				end
				acc = (acc >= orr) ? acc - orr : 0;
			end
			if (last) begin
				cnt = 0;
				while (acc + ir <= orr && cnt < lrp_pkg::MAX_RATIO) begin
					push_pcm(blend_pcm(cur, cur, 0, orr));
					cnt++;
					acc += ir;
				end
				held      = '0;
				have_held = 1'b0;
				phase     = '0;
			end else begin
				held      = s;
				have_held = 1'b1;
				phase     = lrp_pkg::rate_t'(acc);
			end
			if (pcm_q.size() > first_new)
				pcm_q[pcm_q.size() - 1].run_end = 1'b1;
		endfunction

		task check_result(lrp_pkg::pcm_t got_pcm, logic got_end);
			pcm_beat_t want;
			if (pcm_q.size() == 0) begin
				report($sformatf("unexpected beat pcm %0d run_end %0b", got_pcm, got_end));
				return;
			end
			want = pcm_q.pop_front();
			if (got_pcm !== want.pcm)
				report($sformatf("pcm %0d, want %0d", got_pcm, want.pcm));
			if (got_end !== want.run_end)
				report($sformatf("run_end %0b, want %0b", got_end, want.run_end));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;

	pcm_scoreboard sb = new();

	int unsigned audio_rates[9] = '{8000, 11025, 16000, 22050, 32000, 44100, 48000,
		96000, 192000};

	lrp_in_if  sample_ch ();
	lrp_out_if result_ch ();
	lrp_cfg_if cfg_ch ();

	linear_resampler_to_pcm16 dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_ch.ready <= calm || ($urandom_range(0, 99) >= 8);
	end

	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.pcm, result_ch.run_end);
	end

	task send_sample(lrp_pkg::sample_t s, logic last);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 8) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= s;
		sample_ch.last   <= last;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		sb.note_sample(s, last);
	endtask

	task write_rate(lrp_pkg::reg_idx_t idx, lrp_pkg::rate_t val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.set_rate(idx, val);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task drain();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// a beat with no results may still be in flight after the last pcm beat
	task settle();
		drain();
		repeat (450) @(posedge clk);
	endtask

	task set_rates(lrp_pkg::rate_t in_val, lrp_pkg::rate_t out_val);
		settle();
		write_rate(lrp_pkg::REG_IN_RATE, in_val);
		write_rate(lrp_pkg::REG_OUT_RATE, out_val);
	endtask

	function lrp_pkg::rate_t pick_rate();
		case ($urandom_range(0, 11))
			0, 1, 2, 3, 4: return lrp_pkg::rate_t'(audio_rates[$urandom_range(0, 8)]);
			5, 6:          return lrp_pkg::rate_t'($urandom_range(1, 192000));
			7:             return lrp_pkg::rate_t'($urandom);
			8:             return lrp_pkg::rate_t'(1);
			9:             return lrp_pkg::rate_t'(192000);
			10:            return lrp_pkg::rate_t'(0);
			default:       return lrp_pkg::rate_t'($urandom_range(1, 64));
		endcase
	endfunction

	function lrp_pkg::sample_t pick_sample();
		if ($urandom_range(0, 9) < 7)
			return lrp_pkg::sample_t'($urandom);
		return lrp_pkg::sample_t'(int'($urandom_range(0, 140000)) - 70000);
	endfunction

	initial begin
		int   items;
		int   stream_left;
		int   phase_left;
		logic last;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		sample_ch.last   = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = lrp_pkg::REG_IN_RATE;
		cfg_ch.data      = '0;
		arst_n           = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// downsampling at the reset rates, sample extremes and clamping
		send_sample(lrp_pkg::sample_t'(0), 1'b0);
		send_sample(lrp_pkg::sample_t'(524287), 1'b0);
		send_sample(lrp_pkg::sample_t'(-524288), 1'b0);
		send_sample(lrp_pkg::sample_t'(65536), 1'b0);
		send_sample(lrp_pkg::sample_t'(-65536), 1'b0);
		send_sample(lrp_pkg::sample_t'(65537), 1'b0);
		send_sample(lrp_pkg::sample_t'(-65537), 1'b0);
		send_sample(lrp_pkg::sample_t'(12345), 1'b1);

		set_rates(lrp_pkg::rate_t'(16000), lrp_pkg::rate_t'(48000));
		send_sample(lrp_pkg::sample_t'(524287), 1'b0);
		send_sample(lrp_pkg::sample_t'(-524288), 1'b0);
		send_sample(lrp_pkg::sample_t'(100), 1'b0);
		send_sample(lrp_pkg::sample_t'(-100), 1'b1);
		// first beat of a stream that is also its last
		send_sample(lrp_pkg::sample_t'(524287), 1'b1);

		// equal rates
		set_rates(lrp_pkg::rate_t'(44100), lrp_pkg::rate_t'(44100));
		send_sample(lrp_pkg::sample_t'(1000), 1'b0);
		send_sample(lrp_pkg::sample_t'(-1000), 1'b0);
		send_sample(lrp_pkg::sample_t'(7), 1'b1);

		// zero rates behave as one
		set_rates(lrp_pkg::rate_t'(0), lrp_pkg::rate_t'(0));
		send_sample(lrp_pkg::sample_t'(-1), 1'b0);
		send_sample(lrp_pkg::sample_t'(1), 1'b1);

		// output rate above the ratio limit
		set_rates(lrp_pkg::rate_t'(1000), lrp_pkg::rate_t'(192000));
		send_sample(lrp_pkg::sample_t'(0), 1'b0);
		send_sample(lrp_pkg::sample_t'(65536), 1'b0);
		send_sample(lrp_pkg::sample_t'(-65536), 1'b1);

		// rate change in the middle of a stream
		set_rates(lrp_pkg::rate_t'(3000), lrp_pkg::rate_t'(7000));
		send_sample(lrp_pkg::sample_t'(30000), 1'b0);
		send_sample(lrp_pkg::sample_t'(-30000), 1'b0);
		set_rates(lrp_pkg::rate_t'(100), lrp_pkg::rate_t'(1600));
		send_sample(lrp_pkg::sample_t'(50000), 1'b1);

		items       = 0;
		stream_left = 0;
		phase_left  = 0;
		while (items < 286) begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 3))
					0: begin
						settle();
						write_rate(lrp_pkg::REG_IN_RATE, pick_rate());
					end
					1: begin
						settle();
						write_rate(lrp_pkg::REG_OUT_RATE, pick_rate());
					end
					2: begin
						settle();
						write_rate(lrp_pkg::REG_OUT_RATE, pick_rate());
						write_rate(lrp_pkg::REG_IN_RATE, pick_rate());
					end
					default: set_rates(pick_rate(), pick_rate());
				endcase
				phase_left = $urandom_range(15, 40);
			end
			if (stream_left == 0)
				stream_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
			calm = (items >= 120 && items < 200);
			if ($urandom_range(0, 59) == 0)
				drain();
			stream_left--;
			last = (stream_left == 0);
			if (!last && $urandom_range(0, 49) == 0) begin
				last        = 1'b1;
				stream_left = 0;
			end
			send_sample(pick_sample(), last);
			items++;
			phase_left--;
		end
		calm = 1'b0;

		drain();
		repeat (450) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d pcm beats never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/lrp_pkg.sv
sv/lrp_in_if.sv
sv/lrp_out_if.sv
sv/lrp_cfg_if.sv
sv/lrp_datapath.sv
sv/lrp_ctrl.sv
sv/linear_resampler_to_pcm16.sv
tb/testbench.sv
